### rtl/rrac_pkg.sv
`timescale 1ns / 1ps
package rrac_pkg;

  localparam int ROUNDS_DEF = 5;
  localparam int RCON_W     = 4;
  localparam int KEY_W      = 64;
  localparam int BLK_W      = 128;

  // register indexes of the config port
  localparam logic [0:0] REG_KEY_HI = 1'b0;
  localparam logic [0:0] REG_KEY_LO = 1'b1;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD_ENC,
    OP_LOAD_DEC,
    OP_ENC_RND,
    OP_ENC_LAST,
    OP_KEY_FWD,
    OP_DEC_INIT,
    OP_DEC_RND,
    OP_DEC_LAST
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [RCON_W-1:0]   rcon_idx;
  } rrac_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] rcon(input logic [RCON_W-1:0] idx);
    logic [7:0] v;
    case (idx)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/rrac_ctrl.sv
`timescale 1ns / 1ps
module rrac_ctrl #(
  parameter int ROUNDS = rrac_pkg::ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               func,
  output logic               busy,
  output logic               done,
  output rrac_pkg::rrac_cmd_t cmd
);

  localparam int CW = $clog2(ROUNDS + 2);
  localparam logic [CW-1:0] LAST_RND = CW'(ROUNDS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ENC   = 6'b000010,
    S_EXP   = 6'b000100,
    S_DINIT = 6'b001000,
    S_DRND  = 6'b010000,
    S_DLAST = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    done_nxt     = 1'b0;
    cmd.op       = rrac_pkg::OP_HOLD;
    cmd.rcon_idx = rrac_pkg::RCON_W'(cnt_r);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cnt_nxt   = CW'(1);
          cmd.op    = func ? rrac_pkg::OP_LOAD_DEC : rrac_pkg::OP_LOAD_ENC;
          state_nxt = func ? S_EXP : S_ENC;
        end
      end
      S_ENC: begin
        if (cnt_r == LAST_RND) begin
          cmd.op    = rrac_pkg::OP_ENC_LAST;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.op  = rrac_pkg::OP_ENC_RND;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_EXP: begin
        // run the schedule forward up to the last round key
        cmd.op = rrac_pkg::OP_KEY_FWD;
        if (cnt_r == LAST_RND) state_nxt = S_DINIT;
        else cnt_nxt = cnt_r + CW'(1);
      end
      S_DINIT: begin
        cmd.op    = rrac_pkg::OP_DEC_INIT;
        state_nxt = (cnt_r == CW'(1)) ? S_DLAST : S_DRND;
      end
      S_DRND: begin
        // undoes key cnt, applies key cnt-1
        cmd.op  = rrac_pkg::OP_DEC_RND;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(2)) state_nxt = S_DLAST;
      end
      S_DLAST: begin
        cmd.op    = rrac_pkg::OP_DEC_LAST;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;

endmodule

### rtl/rrac_dp.sv
`timescale 1ns / 1ps
module rrac_dp (
  input  logic                          clk,
  input  rrac_pkg::rrac_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_addr,
  input  logic [rrac_pkg::KEY_W-1:0]    cfg_wdata,
  input  logic [rrac_pkg::BLK_W-1:0]    data,
  input  logic                          rst_n,
  output logic [rrac_pkg::BLK_W-1:0]    result
);

  typedef logic [rrac_pkg::BLK_W-1:0] blk_t;

  logic [rrac_pkg::KEY_W-1:0] key_hi_r, key_lo_r;
  blk_t st_r, st_nxt, key_r, key_nxt;

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] aff_inv(input logic [7:0] x);
    return {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05;
  endfunction

  function automatic logic [7:0] sb(input logic [7:0] x, input logic inv);
    logic [7:0] v;
    // inverse box from the forward table: affine inverse around it
    if (inv) v = aff_inv(rrac_pkg::SBOX[aff_inv(x)]);
    else v = rrac_pkg::SBOX[x];
    return v;
  endfunction

  function automatic blk_t sub_st(input blk_t s, input logic inv);
    blk_t o;
    for (int b = 0; b < 16; b++) o[127-8*b -: 8] = sb(s[127-8*b -: 8], inv);
    return o;
  endfunction

  function automatic blk_t shift_st(input blk_t s, input logic inv);
    blk_t o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[127-8*(4*r+c) -: 8] = inv ? s[127-8*(4*r+((c+4-r)&3)) -: 8]
                                    : s[127-8*(4*r+((c+r)&3)) -: 8];
    return o;
  endfunction

  function automatic blk_t mix_st(input blk_t s, input logic inv);
    blk_t o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]  = s[127-8*(4*i+c) -: 8];
        x2[i] = xt(a[i]);
        x4[i] = xt(x2[i]);
        x8[i] = xt(x4[i]);
      end
      for (int i = 0; i < 4; i++) begin
        if (inv)
          o[127-8*(4*i+c) -: 8] = (x8[i] ^ x4[i] ^ x2[i])
                                ^ (x8[(i+1)&3] ^ x2[(i+1)&3] ^ a[(i+1)&3])
                                ^ (x8[(i+2)&3] ^ x4[(i+2)&3] ^ a[(i+2)&3])
                                ^ (x8[(i+3)&3] ^ a[(i+3)&3]);
        else
          o[127-8*(4*i+c) -: 8] = x2[i] ^ x2[(i+1)&3] ^ a[(i+1)&3]
                                ^ a[(i+2)&3] ^ a[(i+3)&3];
      end
    end
    return o;
  endfunction

  // column 3 rotated and substituted, for the schedule
  function automatic logic [31:0] sched_t(input blk_t k);
    logic [31:0] t;
    for (int i = 0; i < 4; i++)
      t[31-8*i -: 8] = rrac_pkg::SBOX[k[127-8*(4*((i+1)&3)+3) -: 8]];
    return t;
  endfunction

  function automatic blk_t key_fwd(input blk_t k, input logic [7:0] rc);
    blk_t o;
    logic [31:0] t;
    t = sched_t(k);
    o = k;
    for (int i = 0; i < 4; i++) o[127-32*i -: 8] = k[127-32*i -: 8] ^ t[31-8*i -: 8];
    o[127 -: 8] = o[127 -: 8] ^ rc;
    for (int j = 1; j < 4; j++)
      for (int i = 0; i < 4; i++)
        o[127-8*(4*i+j) -: 8] = k[127-8*(4*i+j) -: 8] ^ o[127-8*(4*i+j-1) -: 8];
    return o;
  endfunction

  function automatic blk_t key_bwd(input blk_t k, input logic [7:0] rc);
    blk_t o;
    logic [31:0] t;
    o = k;
    for (int j = 1; j < 4; j++)
      for (int i = 0; i < 4; i++)
        o[127-8*(4*i+j) -: 8] = k[127-8*(4*i+j) -: 8] ^ k[127-8*(4*i+j-1) -: 8];
    t = sched_t(o);
    for (int i = 0; i < 4; i++) o[127-32*i -: 8] = k[127-32*i -: 8] ^ t[31-8*i -: 8];
    o[127 -: 8] = o[127 -: 8] ^ rc;
    return o;
  endfunction

  logic [7:0] rc;
  blk_t       cfg_key;
  assign rc      = rrac_pkg::rcon(cmd.rcon_idx);
  assign cfg_key = {key_hi_r, key_lo_r};

  always_comb begin
    st_nxt  = st_r;
    key_nxt = key_r;
    case (cmd.op)
      rrac_pkg::OP_LOAD_ENC: begin
        key_nxt = cfg_key;
        st_nxt  = data ^ cfg_key;
      end
      rrac_pkg::OP_LOAD_DEC: begin
        key_nxt = cfg_key;
        st_nxt  = data;
      end
      rrac_pkg::OP_ENC_RND: begin
        key_nxt = key_fwd(key_r, rc);
        st_nxt  = mix_st(shift_st(sub_st(st_r, 1'b0), 1'b0), 1'b0) ^ key_nxt;
      end
      rrac_pkg::OP_ENC_LAST: begin
        key_nxt = key_fwd(key_r, rc);
        st_nxt  = sub_st(st_r, 1'b0) ^ key_nxt;
      end
      rrac_pkg::OP_KEY_FWD: key_nxt = key_fwd(key_r, rc);
      rrac_pkg::OP_DEC_INIT: st_nxt = sub_st(st_r ^ key_r, 1'b1);
      rrac_pkg::OP_DEC_RND: begin
        key_nxt = key_bwd(key_r, rc);
        st_nxt  = sub_st(shift_st(mix_st(st_r ^ key_nxt, 1'b1), 1'b1), 1'b1);
      end
      rrac_pkg::OP_DEC_LAST: begin
        key_nxt = key_bwd(key_r, rc);
        st_nxt  = st_r ^ key_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == rrac_pkg::REG_KEY_HI) key_hi_r <= cfg_wdata;
      if (cfg_addr == rrac_pkg::REG_KEY_LO) key_lo_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    key_r <= key_nxt;
  end

  assign result = st_r;

endmodule

### rtl/reduced_round_aes128_cipher.sv
`timescale 1ns / 1ps
// encrypt: out_valid strobes once the last round is done; a new request is taken once busy falls
// decrypt: the schedule runs forward to the last round key first, then the rounds run backward
// one round unit, one round per cycle; a request is taken only while busy is low
// out_valid shows each result for one cycle only; the receiver cannot stall
// synchronous active-low reset returns the control to idle and clears the key registers to zero
module reduced_round_aes128_cipher #(
  parameter int ROUNDS = rrac_pkg::ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  output logic        out_valid,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  rrac_pkg::rrac_cmd_t cmd;
  logic [rrac_pkg::BLK_W-1:0] result;

  rrac_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd)
  );

  rrac_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .data      ({in_data_hi, in_data_lo}),
    .rst_n     (rst_n),
    .result    (result)
  );

  assign out_result_hi = result[127:64];
  assign out_result_lo = result[63:0];

endmodule

### rtl/rrac_checker.sv
`timescale 1ns / 1ps
module rrac_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("strobe without work");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("reset did not clear");

endmodule

bind reduced_round_aes128_cipher rrac_checker u_rrac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int NR = rrac_pkg::ROUNDS_DEF;

  typedef struct {
    logic         func;
    logic [127:0] blk;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [63:0] in_data_hi = '0;
  logic [63:0] in_data_lo = '0;
  logic        out_valid;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = rrac_pkg::REG_KEY_HI;
  logic [63:0] cfg_wdata = '0;

  request_t     pending_reqs[$];
  logic [127:0] expected_blocks[$];
  logic [63:0]  key_hi_sh = '0;
  logic [63:0]  key_lo_sh = '0;
  logic [127:0] round_key[NR+1];
  logic         no_gaps = 1'b0;
  int           errors = 0;

  reduced_round_aes128_cipher #(.ROUNDS(NR)) DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] xt(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xt(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    // x^254, zero stays zero
    for (int i = 0; i < 254; i++) r = gf_mul(r, x);
    return x == 0 ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] v;
    v = gf_inv(x);
    return v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sub(logic [7:0] x);
    return gf_inv(rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05);
  endfunction

  logic [7:0] sub_tab[256];
  logic [7:0] isub_tab[256];
  initial for (int i = 0; i < 256; i++) begin
    sub_tab[i] = fwd_sub(i[7:0]);
    isub_tab[i] = inv_sub(i[7:0]);
  end

  function automatic logic [127:0] sub_state(logic [127:0] v, logic inv);
    for (int k = 0; k < 16; k++)
      v[127-8*k -: 8] = inv ? isub_tab[v[127-8*k -: 8]] : sub_tab[v[127-8*k -: 8]];
    return v;
  endfunction

  function automatic logic [127:0] shift_state(logic [127:0] v, logic inv);
    logic [127:0] o;
    int s;
    o = v;
    for (int r = 1; r < 4; r++) begin
      s = inv ? 4 - r : r;
      for (int c = 0; c < 4; c++)
        o[127-8*(4*r+c) -: 8] = v[127-8*(4*r+((c+s)&3)) -: 8];
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_state(logic [127:0] v, logic inv);
    logic [7:0] m[4];
    logic [7:0] a[4];
    logic [7:0] acc;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) a[i] = v[127-8*(4*i+c) -: 8];
      for (int i = 0; i < 4; i++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(m[k], a[(i+k)&3]);
        v[127-8*(4*i+c) -: 8] = acc;
      end
    end
    return v;
  endfunction

  task automatic expand_key();
    logic [127:0] tk;
    logic [7:0]   t[4];
    logic [7:0]   rc;
    tk = {key_hi_sh, key_lo_sh};
    rc = 8'h01;
    round_key[0] = tk;
    for (int r = 1; r <= NR; r++) begin
      for (int i = 0; i < 4; i++) t[i] = sub_tab[tk[127-8*(4*((i+1)&3)+3) -: 8]];
      for (int i = 0; i < 4; i++) tk[127-8*(4*i) -: 8] ^= t[i];
      tk[127 -: 8] ^= rc;
      rc = xt(rc);
      // columns chain left to right within each row
      for (int j = 1; j < 4; j++)
        for (int i = 0; i < 4; i++)
          tk[127-8*(4*i+j) -: 8] ^= tk[127-8*(4*i+j-1) -: 8];
      round_key[r] = tk;
    end
  endtask

  function automatic logic [127:0] crypt_block(logic dec, logic [127:0] v);
    if (!dec) begin
      v ^= round_key[0];
      for (int r = 1; r < NR; r++)
        v = mix_state(shift_state(sub_state(v, 1'b0), 1'b0), 1'b0) ^ round_key[r];
      v = sub_state(v, 1'b0) ^ round_key[NR];
    end else begin
      v = sub_state(v ^ round_key[NR], 1'b1);
      for (int r = NR - 1; r >= 1; r--)
        v = sub_state(shift_state(mix_state(v ^ round_key[r], 1'b1), 1'b1), 1'b1);
      v ^= round_key[0];
    end
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    request_t rq;
    if (start && !busy) begin
      rq = pending_reqs.pop_front();
      expected_blocks.push_back(crypt_block(rq.func, rq.blk));
    end
    if (rst_n && pending_reqs.size() > 0 && (no_gaps || $urandom_range(99) >= 34)) begin
      start      <= 1'b1;
      in_func    <= pending_reqs[0].func;
      in_data_hi <= pending_reqs[0].blk[127:64];
      in_data_lo <= pending_reqs[0].blk[63:0];
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_valid) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, out_result_hi, out_result_lo);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        if (out_result_hi !== want[127:64]) begin
          $display("%0t: result_hi expected %h got %h", $time, want[127:64], out_result_hi);
          errors++;
        end
        if (out_result_lo !== want[63:0]) begin
          $display("%0t: result_lo expected %h got %h", $time, want[63:0], out_result_lo);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == rrac_pkg::REG_KEY_HI) key_hi_sh = val;
    else key_lo_sh = val;
    expand_key();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_req(logic f, logic [127:0] b);
    request_t rq;
    rq.func = f;
    rq.blk  = b;
    pending_reqs.push_back(rq);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_blocks.size() > 0 || start) @(posedge clk);
    repeat (2 * NR + 4) @(posedge clk);
  endtask

  function automatic logic [127:0] rnd128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    // tables are filled by now
    expand_key();
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset key, extremes, walking bits
    queue_req(1'b0, '0);
    queue_req(1'b1, '0);
    queue_req(1'b0, '1);
    queue_req(1'b1, '1);
    drain();
    write_reg(rrac_pkg::REG_KEY_HI, '1);
    write_reg(rrac_pkg::REG_KEY_LO, '1);
    queue_req(1'b0, '0);
    queue_req(1'b1, '1);
    queue_req(1'b0, 128'h00112233_44556677_8899aabb_ccddeeff);
    queue_req(1'b1, 128'h00112233_44556677_8899aabb_ccddeeff);
    drain();
    write_reg(rrac_pkg::REG_KEY_HI, 64'h00010203_04050607);
    write_reg(rrac_pkg::REG_KEY_LO, 64'h08090a0b_0c0d0e0f);
    for (int i = 0; i < 8; i++) begin
      queue_req(i[0], 128'h1 << (i * 17));
      queue_req(~i[0], ~(128'h1 << (i * 17)));
    end
    drain();

    // random phases with changing keys, one phase without gaps
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) begin
        write_reg(rrac_pkg::REG_KEY_HI, '0);
        write_reg(rrac_pkg::REG_KEY_LO, '0);
      end else begin
        write_reg(rrac_pkg::REG_KEY_HI, {$urandom, $urandom});
        write_reg(rrac_pkg::REG_KEY_LO, {$urandom, $urandom});
      end
      no_gaps = (ph == 4);
      for (int i = 0; i < 48; i++) queue_req(1'($urandom_range(1)), rnd128());
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
